[hw/rtl/glpd_pkg.sv]
// Package for the grid local peak detector.
// Holds configuration codes, fixed field widths and the structs shared
// between the front end, the judge and the output queue. No dependencies.
package glpd_pkg;

    localparam int CFG_WIDTH     = 9;
    localparam int CFG_IDX_WIDTH = 1;
    localparam int PEAK_WIDTH    = 8;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COL_COUNT = 1'b1;

    localparam logic [CFG_WIDTH-1:0] CFG_COUNT_RESET = 9'd256;

    // neighbor presence for the sample in the judge stage
    typedef struct packed {
        logic has_up;
        logic has_up2;
        logic has_left;
        logic has_left2;
        logic has_right;
        logic last_row;
        logic last_col;
    } t_ctx;

    // peaks found for one sample, in emit order
    typedef struct packed {
        logic up_center;
        logic left;
        logic self;
    } t_hits;

endpackage

[hw/rtl/glpd_ram.sv]
// Generic line memory: one write port, two read ports, registered reads.
// Read-first on a same-address write. No dependencies.
module glpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

[hw/rtl/glpd_front.sv]
// Front end: grid position counters, the two line buffers and the judge
// stage register. Depends on glpd_pkg and glpd_ram.
module glpd_front #(
    parameter int MAX_COLS     = 256,
    parameter int MAX_ROWS     = 256,
    parameter int SAMPLE_WIDTH = 16,
    parameter int RW           = 8,
    parameter int CW           = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [glpd_pkg::CFG_WIDTH-1:0]   i_row_cfg,
    input  logic [glpd_pkg::CFG_WIDTH-1:0]   i_col_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_pixel_value,
    input  logic                             i_advance,
    output logic                             o_s1_valid,
    output logic signed [SAMPLE_WIDTH-1:0]   o_x,
    output logic signed [SAMPLE_WIDTH-1:0]   o_xm1,
    output logic signed [SAMPLE_WIDTH-1:0]   o_xm2,
    output logic signed [SAMPLE_WIDTH-1:0]   o_pm1,
    output logic signed [SAMPLE_WIDTH-1:0]   o_prev_c,
    output logic signed [SAMPLE_WIDTH-1:0]   o_prev_cp1,
    output logic signed [SAMPLE_WIDTH-1:0]   o_cur_c,
    output logic [RW-1:0]                    o_row,
    output logic [CW-1:0]                    o_col,
    output glpd_pkg::t_ctx                   o_ctx
);

    localparam int CFW = glpd_pkg::CFG_WIDTH;
    localparam int CEW = ($clog2(MAX_COLS + 1) > CFW) ? $clog2(MAX_COLS + 1) : CFW;
    localparam int REW = ($clog2(MAX_ROWS + 1) > CFW) ? $clog2(MAX_ROWS + 1) : CFW;

    logic [CEW-1:0] cols_ext, eff_cols, col_nxt_ext;
    logic [REW-1:0] rows_ext, eff_rows, row_nxt_ext;
    logic           accept, wrap, end_col, end_frame;
    logic [RW-1:0]  r_row, n_row, pos_row;
    logic [CW-1:0]  r_col, n_col, pos_col, addr_b;
    logic           r_sel, n_sel, pos_sel;
    logic           r_s1_valid, n_s1_valid;
    logic           r_s1_sel;
    glpd_pkg::t_ctx ctx;
    logic [SAMPLE_WIDTH-1:0] even_a, even_b, odd_a, odd_b;

    assign cols_ext = CEW'(i_col_cfg);
    assign rows_ext = REW'(i_row_cfg);
    assign eff_cols = (i_col_cfg == '0) ? CEW'(1) :
                      (cols_ext > CEW'(MAX_COLS)) ? CEW'(MAX_COLS) : cols_ext;
    assign eff_rows = (i_row_cfg == '0) ? REW'(1) :
                      (rows_ext > REW'(MAX_ROWS)) ? REW'(MAX_ROWS) : rows_ext;

    assign o_ready = !r_s1_valid || i_advance;
    assign accept  = i_valid && o_ready;

    // position outside a shrunken grid restarts the frame
    assign wrap    = (REW'(r_row) >= eff_rows) || (CEW'(r_col) >= eff_cols);
    assign pos_row = wrap ? '0 : r_row;
    assign pos_col = wrap ? '0 : r_col;
    assign pos_sel = wrap ? 1'b0 : r_sel;

    assign col_nxt_ext = CEW'(pos_col) + CEW'(1);
    assign row_nxt_ext = REW'(pos_row) + REW'(1);
    assign end_col     = (col_nxt_ext >= eff_cols);
    assign end_frame   = end_col && (row_nxt_ext >= eff_rows);
    assign addr_b      = pos_col + CW'(1);

    always_comb begin
        ctx.has_up    = (pos_row != '0);
        ctx.has_up2   = (pos_row > RW'(1));
        ctx.has_left  = (pos_col != '0);
        ctx.has_left2 = (pos_col > CW'(1));
        ctx.has_right = !end_col;
        ctx.last_row  = (row_nxt_ext == eff_rows);
        ctx.last_col  = end_col;
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_sel = r_sel;
        if (accept) begin
            if (end_frame) begin
                n_row = '0;
                n_col = '0;
                n_sel = 1'b0;
            end else if (end_col) begin
                n_row = pos_row + RW'(1);
                n_col = '0;
                n_sel = !pos_sel;
            end else begin
                n_row = pos_row;
                n_col = pos_col + CW'(1);
                n_sel = pos_sel;
            end
        end
        n_s1_valid = accept ? 1'b1 : (i_advance ? 1'b0 : r_s1_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_sel      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_sel      <= n_sel;
            r_s1_valid <= n_s1_valid;
        end
    end

    // stage registers; previous-sample taps come from the last transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_x      <= i_pixel_value;
            o_xm1    <= o_x;
            o_xm2    <= o_xm1;
            o_pm1    <= o_prev_c;
            r_s1_sel <= pos_sel;
            o_row    <= pos_row;
            o_col    <= pos_col;
            o_ctx    <= ctx;
        end
    end

    glpd_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_line_even (
        .i_clk     (i_clk),
        .i_we      (accept && !pos_sel),
        .i_waddr   (pos_col),
        .i_wdata   (i_pixel_value),
        .i_re      (accept),
        .i_raddr_a (pos_col),
        .i_raddr_b (addr_b),
        .o_rdata_a (even_a),
        .o_rdata_b (even_b)
    );

    glpd_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_line_odd (
        .i_clk     (i_clk),
        .i_we      (accept && pos_sel),
        .i_waddr   (pos_col),
        .i_wdata   (i_pixel_value),
        .i_re      (accept),
        .i_raddr_a (pos_col),
        .i_raddr_b (addr_b),
        .o_rdata_a (odd_a),
        .o_rdata_b (odd_b)
    );

    assign o_s1_valid = r_s1_valid;
    assign o_prev_c   = $signed(r_s1_sel ? even_a : odd_a);
    assign o_prev_cp1 = $signed(r_s1_sel ? even_b : odd_b);
    assign o_cur_c    = $signed(r_s1_sel ? odd_a : even_a);

endmodule

[hw/rtl/glpd_judge.sv]
// Neighbor compares for the sample in the judge stage: the center one row
// up, the left neighbor on the last row, and the sample itself at frame end.
// Depends on glpd_pkg.
module glpd_judge #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_xm1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_xm2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_pm1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_prev_c,
    input  logic signed [SAMPLE_WIDTH-1:0] i_prev_cp1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_cur_c,
    input  glpd_pkg::t_ctx                 i_ctx,
    output glpd_pkg::t_hits                o_hits
);

    always_comb begin
        o_hits.up_center = i_ctx.has_up
                        && (!i_ctx.has_up2   || i_prev_c >= i_cur_c)
                        && (i_prev_c >= i_x)
                        && (!i_ctx.has_left  || i_prev_c >= i_pm1)
                        && (!i_ctx.has_right || i_prev_c >= i_prev_cp1);
        o_hits.left      = i_ctx.last_row && i_ctx.has_left
                        && (!i_ctx.has_up    || i_xm1 >= i_pm1)
                        && (!i_ctx.has_left2 || i_xm1 >= i_xm2)
                        && (i_xm1 >= i_x);
        o_hits.self      = i_ctx.last_row && i_ctx.last_col
                        && (!i_ctx.has_up    || i_x >= i_prev_c)
                        && (!i_ctx.has_left  || i_x >= i_xm1);
    end

endmodule

[hw/rtl/glpd_outq.sv]
// Result register: holds up to three peaks of one sample and hands them
// out one transaction per cycle while i_ready is high. Depends on glpd_pkg.
module glpd_outq #(
    parameter int RW = 8,
    parameter int CW = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s1_valid,
    input  glpd_pkg::t_hits                     i_hits,
    input  logic [RW-1:0]                       i_row,
    input  logic [CW-1:0]                       i_col,
    output logic                                o_advance,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [glpd_pkg::PEAK_WIDTH-1:0]     o_peak_row,
    output logic [glpd_pkg::PEAK_WIDTH-1:0]     o_peak_col,
    output logic                                o_last_of_run
);

    localparam int PW = glpd_pkg::PEAK_WIDTH;

    glpd_pkg::t_hits r_pend, n_pend, after;
    logic [RW-1:0]   r_row, row_up;
    logic [CW-1:0]   r_col, col_left;
    logic            busy, free, load, any_hit;

    assign row_up   = r_row - RW'(1);
    assign col_left = r_col - CW'(1);

    always_comb begin
        after = r_pend;
        if (r_pend.up_center) begin
            after.up_center = 1'b0;
            o_peak_row      = PW'(row_up);
            o_peak_col      = PW'(r_col);
        end else if (r_pend.left) begin
            after.left      = 1'b0;
            o_peak_row      = PW'(r_row);
            o_peak_col      = PW'(col_left);
        end else begin
            after.self      = 1'b0;
            o_peak_row      = PW'(r_row);
            o_peak_col      = PW'(r_col);
        end
    end

    assign busy          = (r_pend != '0);
    assign o_valid       = busy;
    assign o_last_of_run = (after == '0);
    assign free          = !busy || (i_ready && o_last_of_run);
    assign any_hit       = (i_hits != '0);
    assign o_advance     = i_s1_valid && (!any_hit || free);
    assign load          = i_s1_valid && any_hit && free;

    always_comb begin
        n_pend = r_pend;
        if (load) begin
            n_pend = i_hits;
        end else if (busy && i_ready) begin
            n_pend = after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_row <= i_row;
            r_col <= i_col;
        end
    end

endmodule

[hw/rtl/grid_local_peak_detector_top.sv]
// Grid local peak detector, top level: configuration registers and the
// front end, judge and result register. Depends on glpd_pkg, glpd_front,
// glpd_judge, glpd_outq.
//
// Usage: samples enter in raster order on the input channel (i_valid,
// o_ready, i_pixel_value); peak coordinates leave on the output channel
// (o_valid, i_ready, o_peak_row, o_peak_col, o_last_of_run). Grid size is
// set by writing row and column counts through i_cfg_we/i_cfg_index/
// i_cfg_data while the block is idle.
// A sample at (r, c) judges (r-1, c); on the last row it also judges
// (r, c-1), and the final sample judges itself, so up to three peaks follow
// one sample, the last one flagged by o_last_of_run.
// Path: the sample that decides a peak is registered in the judge stage,
// with its line buffer reads, and its peaks then load the result register,
// which drives o_valid; a busy result register can hold them back.
// Throughput: one sample per cycle while i_ready is high and each sample
// yields at most one peak; a sample's peaks leave the result register in turn.
// A stalled receiver holds the result register; a sample with peaks then
// waits in the judge stage and o_ready drops. Samples without peaks pass.
// Reset clears the position to (0, 0), both counts to 256 and all pending
// results; line buffer contents are not cleared.
module grid_local_peak_detector_top #(
    parameter int MAX_COLS     = 256,
    parameter int MAX_ROWS     = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [glpd_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [glpd_pkg::CFG_WIDTH-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_pixel_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [glpd_pkg::PEAK_WIDTH-1:0]       o_peak_row,
    output logic [glpd_pkg::PEAK_WIDTH-1:0]       o_peak_col,
    output logic                                  o_last_of_run
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [glpd_pkg::CFG_WIDTH-1:0] r_row_cfg, n_row_cfg, r_col_cfg, n_col_cfg;
    logic                           s1_valid, advance;
    logic signed [SAMPLE_WIDTH-1:0] x, xm1, xm2, pm1, prev_c, prev_cp1, cur_c;
    logic [RW-1:0]                  s1_row;
    logic [CW-1:0]                  s1_col;
    glpd_pkg::t_ctx                 s1_ctx;
    glpd_pkg::t_hits                hits;

    always_comb begin
        n_row_cfg = r_row_cfg;
        n_col_cfg = r_col_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                glpd_pkg::CFG_ROW_COUNT: n_row_cfg = i_cfg_data;
                glpd_pkg::CFG_COL_COUNT: n_col_cfg = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cfg <= glpd_pkg::CFG_COUNT_RESET;
            r_col_cfg <= glpd_pkg::CFG_COUNT_RESET;
        end else begin
            r_row_cfg <= n_row_cfg;
            r_col_cfg <= n_col_cfg;
        end
    end

    glpd_front #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .RW           (RW),
        .CW           (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_row_cfg     (r_row_cfg),
        .i_col_cfg     (r_col_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .i_advance     (advance),
        .o_s1_valid    (s1_valid),
        .o_x           (x),
        .o_xm1         (xm1),
        .o_xm2         (xm2),
        .o_pm1         (pm1),
        .o_prev_c      (prev_c),
        .o_prev_cp1    (prev_cp1),
        .o_cur_c       (cur_c),
        .o_row         (s1_row),
        .o_col         (s1_col),
        .o_ctx         (s1_ctx)
    );

    glpd_judge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_judge (
        .i_x        (x),
        .i_xm1      (xm1),
        .i_xm2      (xm2),
        .i_pm1      (pm1),
        .i_prev_c   (prev_c),
        .i_prev_cp1 (prev_cp1),
        .i_cur_c    (cur_c),
        .i_ctx      (s1_ctx),
        .o_hits     (hits)
    );

    glpd_outq #(
        .RW (RW),
        .CW (CW)
    ) u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (s1_valid),
        .i_hits        (hits),
        .i_row         (s1_row),
        .i_col         (s1_col),
        .o_advance     (advance),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_peak_row    (o_peak_row),
        .o_peak_col    (o_peak_col),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for grid_local_peak_detector_top: streams grids of samples,
// predicts every peak coordinate in a scoreboard class and compares each output transaction.
// Depends on glpd_pkg and grid_local_peak_detector_top.
module tb;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
        logic       last;
    } t_peak;

    typedef enum int {GEN_RANDOM, GEN_NARROW, GEN_FLAT} t_gen;

    class peak_scoreboard;
        int          line_mem[2][256];
        int unsigned pos_row;
        int unsigned pos_col;
        int unsigned rows_cfg;
        int unsigned cols_cfg;
        bit          bank;
        t_peak       expected_q[$];
        int          errors;
        int          samples;
        int          peaks;

        function new();
            foreach (line_mem[i, j]) line_mem[i][j] = 0;
            pos_row = 0;
            pos_col = 0;
            rows_cfg = 256;
            cols_cfg = 256;
            bank = 1'b0;
            errors = 0;
            samples = 0;
            peaks = 0;
        endfunction

        function int unsigned clamp_count(int unsigned cfg);
            if (cfg == 0) return 1;
            return (cfg > 256) ? 256 : cfg;
        endfunction

        function void set_count(logic [glpd_pkg::CFG_IDX_WIDTH-1:0] idx, int unsigned value);
            if (idx == glpd_pkg::CFG_ROW_COUNT) rows_cfg = value & 32'h1ff;
            else cols_cfg = value & 32'h1ff;
        endfunction

        // judges (r-1,c), then on the last row (r,c-1) and, at the last column, (r,c)
        function void note_sample(logic signed [15:0] v);
            int unsigned rows;
            int unsigned cols;
            int unsigned r;
            int unsigned c;
            int          x;
            int          ctr;
            int          cb;
            int          pb;
            t_peak       hits[$];
            rows = clamp_count(rows_cfg);
            cols = clamp_count(cols_cfg);
            x = v;
            if (pos_row >= rows || pos_col >= cols) begin
                pos_row = 0;
                pos_col = 0;
                bank = 1'b0;
            end
            r = pos_row;
            c = pos_col;
            cb = bank;
            pb = 1 - cb;
            if (r >= 1) begin
                ctr = line_mem[pb][c];
                if ((r < 2 || ctr >= line_mem[cb][c]) && ctr >= x
                        && (c < 1 || ctr >= line_mem[pb][c-1])
                        && (c + 1 >= cols || ctr >= line_mem[pb][c+1]))
                    hits.push_back('{row: 8'(r - 1), col: 8'(c), last: 1'b0});
            end
            line_mem[cb][c] = x;
            if (r == rows - 1) begin
                if (c >= 1) begin
                    ctr = line_mem[cb][c-1];
                    if ((r < 1 || ctr >= line_mem[pb][c-1])
                            && (c < 2 || ctr >= line_mem[cb][c-2]) && ctr >= x)
                        hits.push_back('{row: 8'(r), col: 8'(c - 1), last: 1'b0});
                end
                if (c == cols - 1) begin
                    if ((r < 1 || x >= line_mem[pb][c]) && (c < 1 || x >= line_mem[cb][c-1]))
                        hits.push_back('{row: 8'(r), col: 8'(c), last: 1'b0});
                end
            end
            pos_col = c + 1;
            if (pos_col >= cols) begin
                pos_col = 0;
                pos_row = r + 1;
                bank = !bank;
                if (pos_row >= rows) begin
                    pos_row = 0;
                    bank = 1'b0;
                end
            end
            if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
            foreach (hits[i]) expected_q.push_back(hits[i]);
            samples++;
        endfunction

        function void check_peak(logic [7:0] row, logic [7:0] col, logic last);
            t_peak want;
            if (expected_q.size() == 0) begin
                $error("peak (%0d,%0d) with nothing expected", row, col);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            peaks++;
            if (row !== want.row) begin
                $error("peak_row: expected %0d, got %0d", want.row, row);
                errors++;
            end
            if (col !== want.col) begin
                $error("peak_col: expected %0d, got %0d", want.col, col);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [glpd_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index;
    logic [glpd_pkg::CFG_WIDTH-1:0]       i_cfg_data;
    logic                                 i_valid;
    logic                                 o_ready;
    logic signed [15:0]                   i_pixel_value;
    logic                                 o_valid;
    logic                                 i_ready;
    logic [glpd_pkg::PEAK_WIDTH-1:0]      o_peak_row;
    logic [glpd_pkg::PEAK_WIDTH-1:0]      o_peak_col;
    logic                                 o_last_of_run;

    peak_scoreboard sb;
    bit             steady;
    bit             long_hold_req;
    int             grids;
    int             quiet_cycles;

    grid_local_peak_detector_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_peak_row    (o_peak_row),
        .o_peak_col    (o_peak_col),
        .o_last_of_run (o_last_of_run)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic int unsigned pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 0;
        if (roll == 1) return $urandom_range(9, 16);
        return $urandom_range(1, 8);
    endfunction

    task automatic send_sample(input logic signed [15:0] v);
        int unsigned gap;
        gap = (steady || $urandom_range(0, 99) < 70) ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(v);
    endtask

    task automatic feed_samples(input int unsigned n, input t_gen mode);
        logic signed [15:0] base;
        logic signed [15:0] v;
        base = $urandom;
        for (int i = 0; i < n; i++) begin
            case (mode)
                GEN_RANDOM: v = $urandom;
                GEN_NARROW: v = 16'($urandom_range(0, 4)) - 16'd2;
                default:    v = base;
            endcase
            send_sample(v);
        end
    endtask

    // sender stops until every peak has arrived, then the pipeline settles
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_grid(input int unsigned rows_val, input int unsigned cols_val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= glpd_pkg::CFG_ROW_COUNT;
        i_cfg_data <= 9'(rows_val);
        @(negedge i_clk);
        i_cfg_index <= glpd_pkg::CFG_COL_COUNT;
        i_cfg_data <= 9'(cols_val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_count(glpd_pkg::CFG_ROW_COUNT, rows_val);
        sb.set_count(glpd_pkg::CFG_COL_COUNT, cols_val);
        grids++;
    endtask

    initial begin : rx
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                hold_left = 80;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (steady) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_peak(o_peak_row, o_peak_col, o_last_of_run);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 1000) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stim
        int unsigned rcfg;
        int unsigned ccfg;
        int unsigned rc;
        int unsigned cc;
        int unsigned n;
        int unsigned rand_items;
        t_gen        mode;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = glpd_pkg::CFG_ROW_COUNT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel_value = '0;
        steady = 1'b0;
        long_hold_req = 1'b0;
        grids = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one-sample grid: always its own peak
        set_grid(1, 1);
        send_sample(-16'sd32768);
        drain();
        // zero row count acts as one row
        set_grid(0, 3);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        drain();
        set_grid(3, 1);
        send_sample(-16'sd1);
        send_sample(16'sd5);
        send_sample(16'sd5);
        drain();
        // ties count as peaks
        set_grid(2, 2);
        repeat (4) send_sample(16'sd7);
        drain();
        // resize mid-frame to a grid that excludes the current position
        set_grid(3, 3);
        send_sample(16'sd3);
        send_sample(-16'sd4);
        send_sample(16'sd9);
        send_sample(16'sd0);
        drain();
        set_grid(1, 3);
        send_sample(16'sd2);
        send_sample(16'sd2);
        send_sample(-16'sd8);
        drain();

        // saturated column count and full row count, both frames cut short
        set_grid(1, 511);
        feed_samples(24, GEN_RANDOM);
        drain();
        set_grid(256, 1);
        feed_samples(24, GEN_NARROW);
        drain();

        // flat grid with a long output stall to back up the input
        set_grid(6, 8);
        steady = 1'b1;
        long_hold_req = 1'b1;
        feed_samples(48, GEN_FLAT);
        drain();
        steady = 1'b0;

        rand_items = 0;
        while (rand_items < 150) begin
            if (sb.pos_row != 0) rcfg = $urandom_range(1, sb.pos_row);
            else rcfg = pick_count();
            ccfg = pick_count();
            rc = (rcfg == 0) ? 1 : rcfg;
            cc = (ccfg == 0) ? 1 : ccfg;
            set_grid(rcfg, ccfg);
            steady = ($urandom_range(0, 4) == 0);
            mode = t_gen'($urandom_range(0, 2));
            n = rc * cc;
            if (rc >= 2 && $urandom_range(0, 6) == 0) n = $urandom_range(cc, n - 1);
            // large grids are cut short at 48 samples
            if (n > 48) n = 48;
            feed_samples(n, mode);
            rand_items += n;
            drain();
        end
        steady = 1'b0;

        $display("Streamed %0d samples over %0d grid settings and compared %0d peaks.",
                 sb.samples, grids, sb.peaks);
        $display("Covered single row and column grids, zero and saturated counts, "
                 , "truncated frames with resize, and a long output stall.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
